// ===== hdl/igr_pkg.sv =====
`timescale 1ns / 1ps

package igr_pkg;

  // Default frame side; the top level hands it down as a parameter.
  localparam int unsigned SIDE_DEF = 256;

  localparam int unsigned FIELD_W = 8;
  localparam int unsigned PIX_W   = 3 * FIELD_W;
  localparam int unsigned CFG_W   = 8;
  localparam int unsigned CFG_IW  = 2;

  // Configuration register indexes
  localparam logic [CFG_IW-1:0] REG_MODE    = 2'd0;
  localparam logic [CFG_IW-1:0] REG_QUAD    = 2'd1;
  localparam logic [CFG_IW-1:0] REG_SHUFFLE = 2'd2;
  localparam logic [CFG_IW-1:0] REG_SHRINK  = 2'd3;

  // Read-out modes
  localparam logic [3:0] MODE_IDENT    = 4'd0;
  localparam logic [3:0] MODE_ROW_FLIP = 4'd1;
  localparam logic [3:0] MODE_COL_FLIP = 4'd2;
  localparam logic [3:0] MODE_ROT90    = 4'd3;
  localparam logic [3:0] MODE_ROT180   = 4'd4;
  localparam logic [3:0] MODE_ROT270   = 4'd5;
  localparam logic [3:0] MODE_MIR_R2L  = 4'd6;
  localparam logic [3:0] MODE_MIR_B2T  = 4'd7;
  localparam logic [3:0] MODE_MIR_T2B  = 4'd8;
  localparam logic [3:0] MODE_MIR_L2R  = 4'd9;
  localparam logic [3:0] MODE_ZOOM     = 4'd10;
  localparam logic [3:0] MODE_SHUFFLE  = 4'd11;
  localparam logic [3:0] MODE_SHRINK   = 4'd12;

  // Item action codes
  localparam logic ACT_STORE = 1'b0;
  localparam logic ACT_READ  = 1'b1;

  // Register reset values
  localparam logic [3:0] MODE_RST    = MODE_IDENT;
  localparam logic [1:0] QUAD_RST    = 2'd0;
  localparam logic [7:0] SHUFFLE_RST = 8'd228;
  localparam logic [2:0] SHRINK_RST  = 3'd2;

  // Controller to datapath
  typedef struct packed {
    logic capture;   // latch the accepted transaction
    logic exec;      // perform the memory access
    logic load_out;  // move the read pixel into the output register
  } igr_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_read;
  } igr_status_t;

endpackage

// ===== hdl/image_geometric_remap.sv =====
`timescale 1ns / 1ps
// Store transaction: accepted, written to the frame memory in the cycle after; the input
//   stalls while the write is performed.
// Read transaction: the frame memory read is registered, then the pixel loads into the
//   output register once it is empty or being taken; the input stall drops as the pixel loads.
// Rate is set by the single-port frame memory with registered read data.
// rst_n (synchronous) clears control and configuration; frame memory content is not reset.

module image_geometric_remap #(
  parameter int unsigned SIDE = igr_pkg::SIDE_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // configuration writes, taken whenever cfg_we is high
  input  logic                        cfg_we,
  input  logic [igr_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [igr_pkg::CFG_W-1:0]   cfg_wdata,
  // input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_action,
  input  logic [igr_pkg::FIELD_W-1:0] in_row,
  input  logic [igr_pkg::FIELD_W-1:0] in_col,
  input  logic [igr_pkg::FIELD_W-1:0] in_red_in,
  input  logic [igr_pkg::FIELD_W-1:0] in_green_in,
  input  logic [igr_pkg::FIELD_W-1:0] in_blue_in,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [igr_pkg::FIELD_W-1:0] out_red_out,
  output logic [igr_pkg::FIELD_W-1:0] out_green_out,
  output logic [igr_pkg::FIELD_W-1:0] out_blue_out
);

  igr_pkg::igr_cmd_t    cmd;
  igr_pkg::igr_status_t status;

  // Controller: sequences capture, memory access and output load per transaction,
  // and holds the output valid flag so a finished pixel can wait while the next
  // transaction is taken in.
  igr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Datapath: configuration registers, coordinate mapping, frame memory and the
  // output register. Pixels outside the frame or outside the shrunken picture read
  // as black.
  igr_dpath #(
    .SIDE (SIDE)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .status        (status),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_action     (in_action),
    .in_row        (in_row),
    .in_col        (in_col),
    .in_red_in     (in_red_in),
    .in_green_in   (in_green_in),
    .in_blue_in    (in_blue_in),
    .out_red_out   (out_red_out),
    .out_green_out (out_green_out),
    .out_blue_out  (out_blue_out)
  );

endmodule

// ===== hdl/igr_ctrl.sv =====
`timescale 1ns / 1ps

module igr_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  igr_pkg::igr_status_t status,
  output igr_pkg::igr_cmd_t    cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_LOAD
  } state_t;

  state_t state_r;
  logic   in_stall_r;
  logic   out_valid_r;
  logic   accept;
  logic   load;

  assign accept = in_valid && !in_stall_r;
  assign load   = (state_r == ST_LOAD) && (!out_valid_r || !out_stall);

  always_comb begin
    cmd          = '0;
    cmd.capture  = accept;
    cmd.exec     = (state_r == ST_EXEC);
    cmd.load_out = load;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      in_stall_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // output register: fill on load, drop once taken
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            state_r    <= ST_EXEC;
            in_stall_r <= 1'b1;
          end
        end
        ST_EXEC: begin
          if (status.is_read) begin
            state_r <= ST_LOAD;
          end else begin
            state_r    <= ST_IDLE;
            in_stall_r <= 1'b0;
          end
        end
        ST_LOAD: begin
          if (load) begin
            state_r    <= ST_IDLE;
            in_stall_r <= 1'b0;
          end
        end
        default: begin
          state_r    <= ST_IDLE;
          in_stall_r <= 1'b0;
        end
      endcase
    end
  end

  assign in_stall  = in_stall_r;
  assign out_valid = out_valid_r;

endmodule

// ===== hdl/igr_dpath.sv =====
`timescale 1ns / 1ps

module igr_dpath #(
  parameter int unsigned SIDE = igr_pkg::SIDE_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  igr_pkg::igr_cmd_t           cmd,
  output igr_pkg::igr_status_t        status,
  input  logic                        cfg_we,
  input  logic [igr_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [igr_pkg::CFG_W-1:0]   cfg_wdata,
  input  logic                        in_action,
  input  logic [igr_pkg::FIELD_W-1:0] in_row,
  input  logic [igr_pkg::FIELD_W-1:0] in_col,
  input  logic [igr_pkg::FIELD_W-1:0] in_red_in,
  input  logic [igr_pkg::FIELD_W-1:0] in_green_in,
  input  logic [igr_pkg::FIELD_W-1:0] in_blue_in,
  output logic [igr_pkg::FIELD_W-1:0] out_red_out,
  output logic [igr_pkg::FIELD_W-1:0] out_green_out,
  output logic [igr_pkg::FIELD_W-1:0] out_blue_out
);

  localparam int unsigned CW    = $clog2(SIDE);
  localparam int unsigned AW    = CW + 2;
  localparam int unsigned XW    = CW + igr_pkg::FIELD_W;
  localparam int unsigned DEPTH = 2 ** (2 * CW);
  localparam int unsigned PW    = igr_pkg::PIX_W;
  localparam int unsigned FW    = igr_pkg::FIELD_W;

  localparam logic [AW-1:0] LAST = AW'(SIDE - 1);
  localparam logic [AW-1:0] HALF = AW'(SIDE / 2);
  localparam logic [AW-1:0] N2   = AW'(SIDE / 2);
  localparam logic [AW-1:0] N3   = AW'(SIDE / 3);
  localparam logic [AW-1:0] N4   = AW'(SIDE / 4);

  // configuration
  logic [3:0] mode_r;
  logic [1:0] quad_r;
  logic [7:0] shuffle_r;
  logic [2:0] shrink_r;

  // captured transaction
  logic          action_r;
  logic [FW-1:0] row_r;
  logic [FW-1:0] col_r;
  logic [PW-1:0] pix_r;

  logic [PW-1:0] mem [DEPTH];
  logic [PW-1:0] mem_q_r;
  logic          blk_r;
  logic [PW-1:0] out_r;

  logic          in_frame;
  logic [AW-1:0] r;
  logic [AW-1:0] c;
  logic [AW-1:0] a;
  logic [AW-1:0] b;
  logic [AW-1:0] sa;
  logic [AW-1:0] sb;
  logic          map_ok;
  logic          qr;
  logic          qc;
  logic [1:0]    src_q;
  logic [2:0]    f;
  logic [AW-1:0] n;
  logic [2*CW-1:0] addr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= igr_pkg::MODE_RST;
      quad_r    <= igr_pkg::QUAD_RST;
      shuffle_r <= igr_pkg::SHUFFLE_RST;
      shrink_r  <= igr_pkg::SHRINK_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        igr_pkg::REG_MODE:    mode_r    <= cfg_wdata[3:0];
        igr_pkg::REG_QUAD:    quad_r    <= cfg_wdata[1:0];
        igr_pkg::REG_SHUFFLE: shuffle_r <= cfg_wdata[7:0];
        igr_pkg::REG_SHRINK:  shrink_r  <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      action_r <= in_action;
      row_r    <= in_row;
      col_r    <= in_col;
      pix_r    <= {in_red_in, in_green_in, in_blue_in};
    end
  end

  assign status.is_read = (action_r == igr_pkg::ACT_READ);

  assign in_frame = (XW'(row_r) < XW'(SIDE)) && (XW'(col_r) < XW'(SIDE));
  assign r = AW'(row_r);
  assign c = AW'(col_r);

  // output coordinate to source coordinate
  always_comb begin
    a      = r;
    b      = c;
    map_ok = 1'b1;
    qr     = (r >= HALF);
    qc     = (c >= HALF);
    src_q  = shuffle_r[{qr, qc, 1'b0} +: 2];
    f      = shrink_r;
    if (shrink_r < 3'd2) begin
      f = 3'd2;
    end else if (shrink_r > 3'd4) begin
      f = 3'd4;
    end
    case (f)
      3'd3:    n = N3;
      3'd4:    n = N4;
      default: n = N2;
    endcase
    case (mode_r)
      igr_pkg::MODE_ROW_FLIP: a = LAST - r;
      igr_pkg::MODE_COL_FLIP: b = LAST - c;
      igr_pkg::MODE_ROT90: begin
        a = LAST - c;
        b = r;
      end
      igr_pkg::MODE_ROT180: begin
        a = LAST - r;
        b = LAST - c;
      end
      igr_pkg::MODE_ROT270: begin
        a = c;
        b = LAST - r;
      end
      igr_pkg::MODE_MIR_R2L: if (!qc) b = LAST - c;
      igr_pkg::MODE_MIR_B2T: if (!qr) a = LAST - r;
      igr_pkg::MODE_MIR_T2B: if (qr) a = LAST - r;
      igr_pkg::MODE_MIR_L2R: if (qc) b = LAST - c;
      igr_pkg::MODE_ZOOM: begin
        a = (quad_r[1] ? HALF : '0) + (r >> 1);
        b = (quad_r[0] ? HALF : '0) + (c >> 1);
      end
      igr_pkg::MODE_SHUFFLE: begin
        a = (src_q[1] ? HALF : '0) + (r - (qr ? HALF : '0));
        b = (src_q[0] ? HALF : '0) + (c - (qc ? HALF : '0));
      end
      igr_pkg::MODE_SHRINK: begin
        map_ok = (r < n) && (c < n);
        case (f)
          3'd3: begin
            a = r + (r << 1);
            b = c + (c << 1);
          end
          3'd4: begin
            a = r << 2;
            b = c << 2;
          end
          default: begin
            a = r << 1;
            b = c << 1;
          end
        endcase
      end
      default: ;
    endcase
    sa = (a > LAST) ? LAST : a;
    sb = (b > LAST) ? LAST : b;
  end

  assign addr = cmd.exec && !status.is_read ? {r[CW-1:0], c[CW-1:0]}
                                            : {sa[CW-1:0], sb[CW-1:0]};

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (!status.is_read) begin
        if (in_frame) begin
          mem[addr] <= pix_r;
        end
      end else begin
        mem_q_r <= mem[addr];
        blk_r   <= !(in_frame && map_ok);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_r <= blk_r ? '0 : mem_q_r;
    end
  end

  assign out_red_out   = out_r[PW-1 -: FW];
  assign out_green_out = out_r[FW +: FW];
  assign out_blue_out  = out_r[FW-1:0];

endmodule
